>>> design/mjt_pkg.sv
// Package: types, constants and state codes for the min-jerk trajectory sampler
`default_nettype none
package mjt_pkg;

  localparam int SAMPLES   = 50;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 6;
  localparam int DUR_W     = 20;
  localparam logic [DUR_W-1:0] DUR_RESET = 20'd65536;

  // Sample time step 2^F/SAMPLES split into quotient and remainder
  localparam int U_STEP = (1 << FRAC_BITS) / SAMPLES;
  localparam int U_REM  = (1 << FRAC_BITS) % SAMPLES;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] HALF_Q  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   sample_index;
    logic signed [31:0] sample_pos;
    logic               last_sample;
  } out_item_t;

  // Sequencer steps: solve, then Horner per sample
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T2,     // t2 = T*T
    ST_AT2,    // at2 = a0*t2
    ST_B1,     // b1 = v0*T
    ST_B2,     // b2 = at2*half
    ST_DV,     // x = ve-v0 (adder)
    ST_H1A,    // x = x*T
    ST_H1B,    // h1t = x - at2
    ST_DA,     // x = ae-a0
    ST_H2,     // h2t2 = x*t2
    ST_H2H,    // h2h = h2t2*half
    ST_H0A,    // h0 = pe-p0
    ST_H0B,    // h0 -= b1
    ST_H0C,    // h0 -= b2
    ST_C3A,    // x = h0*10
    ST_C3B,    // y = h1t*4
    ST_C3C,    // b3 = x-y
    ST_C3D,    // b3 += h2h
    ST_C4A,    // x = h1t*7
    ST_C4B,    // y = h0*15
    ST_C4C,    // x = x-y
    ST_C4D,    // b4 = x-h2t2
    ST_C5A,    // x = h0*6
    ST_C5B,    // y = h1t*3
    ST_C5C,    // x = x-y
    ST_C5D,    // b5 = x+h2h
    ST_HMUL,   // acc = acc*u
    ST_HADD,   // acc = acc+b_k
    ST_EMIT    // hold result until taken
  } state_t;

  typedef struct packed {
    logic               sub;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } alu_op_t;

endpackage
`default_nettype wire

>>> design/min_jerk_trajectory_sampler_core.sv
// Top level: min-jerk quintic solve and sampled evaluation with a shared multiplier
// One input transaction gives SAMPLES output transactions (index, position, last flag).
// Each multiply holds the shared unit for a start step, four 32x32 partial products and a
// result step; each saturating add is done by the combinational adder in its own state.
// The solve is 13 multiplies and 12 adds; each sample is five multiply-adds plus an emit
// state, in which each result waits while out_stall is high.
// The input is stalled for the whole item; duration writes are accepted only while idle.
`default_nettype none
module min_jerk_trajectory_sampler_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mjt_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mjt_pkg::out_item_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [mjt_pkg::DUR_W-1:0]   cfg_duration
);
  mjt_pkg::state_t state_r, state_nxt;
  logic [mjt_pkg::DUR_W-1:0] dur_r;
  mjt_pkg::in_item_t item_r;
  logic signed [63:0] coef_r [6];
  logic signed [63:0] t2_r, at2_r, h0_r, h1_r, h2_r, h2h_r, x_r, y_r, acc_r;
  logic [mjt_pkg::IDX_W-1:0] idx_r;
  logic [2:0] k_r;
  logic [mjt_pkg::FRAC_BITS:0] u_r, u_nxt;
  logic [mjt_pkg::IDX_W:0] rem_r, rem_nxt, rem_sum;
  logic mstart_r;

  logic mul_start, mul_done;
  logic signed [63:0] ma, mb, my, ay;
  mjt_pkg::alu_op_t aop;
  logic signed [63:0] tq, p0, v0, a0, pe, ve, ae;
  logic in_acc, out_acc;

  assign tq = 64'(dur_r);
  assign p0 = 64'(item_r.start_pos); assign v0 = 64'(item_r.start_vel);
  assign a0 = 64'(item_r.start_acc); assign pe = 64'(item_r.end_pos);
  assign ve = 64'(item_r.end_vel);   assign ae = 64'(item_r.end_acc);

  assign in_stall  = state_r != mjt_pkg::ST_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = state_r == mjt_pkg::ST_IDLE;
  assign out_valid = state_r == mjt_pkg::ST_EMIT;
  assign out_acc   = out_valid && !out_stall;

  mjt_mulq u_mul (.clk, .rst_n, .start(mul_start), .a(ma), .b(mb), .done(mul_done), .y(my));
  mjt_sadd u_add (.op(aop), .y(ay));

  // Multiply states start the unit once on entry
  function automatic logic is_mul(mjt_pkg::state_t s);
    case (s)
      mjt_pkg::ST_T2, mjt_pkg::ST_AT2, mjt_pkg::ST_B1, mjt_pkg::ST_B2, mjt_pkg::ST_H1A,
      mjt_pkg::ST_H2, mjt_pkg::ST_H2H, mjt_pkg::ST_C3A, mjt_pkg::ST_C3B, mjt_pkg::ST_C4A,
      mjt_pkg::ST_C4B, mjt_pkg::ST_C5A, mjt_pkg::ST_C5B, mjt_pkg::ST_HMUL: is_mul = 1'b1;
      default: is_mul = 1'b0;
    endcase
  endfunction

  assign mul_start = is_mul(state_r) && mstart_r;

  // Operand selection
  always_comb begin
    ma = '0; mb = '0;
    case (state_r)
      mjt_pkg::ST_T2:   begin ma = tq;    mb = tq; end
      mjt_pkg::ST_AT2:  begin ma = a0;    mb = t2_r; end
      mjt_pkg::ST_B1:   begin ma = v0;    mb = tq; end
      mjt_pkg::ST_B2:   begin ma = at2_r; mb = mjt_pkg::HALF_Q; end
      mjt_pkg::ST_H1A:  begin ma = x_r;   mb = tq; end
      mjt_pkg::ST_H2:   begin ma = x_r;   mb = t2_r; end
      mjt_pkg::ST_H2H:  begin ma = h2_r;  mb = mjt_pkg::HALF_Q; end
      mjt_pkg::ST_C3A:  begin ma = h0_r;  mb = 10 * mjt_pkg::ONE_Q; end
      mjt_pkg::ST_C3B:  begin ma = h1_r;  mb = 4 * mjt_pkg::ONE_Q; end
      mjt_pkg::ST_C4A:  begin ma = h1_r;  mb = 7 * mjt_pkg::ONE_Q; end
      mjt_pkg::ST_C4B:  begin ma = h0_r;  mb = 15 * mjt_pkg::ONE_Q; end
      mjt_pkg::ST_C5A:  begin ma = h0_r;  mb = 6 * mjt_pkg::ONE_Q; end
      mjt_pkg::ST_C5B:  begin ma = h1_r;  mb = 3 * mjt_pkg::ONE_Q; end
      mjt_pkg::ST_HMUL: begin ma = acc_r; mb = 64'(u_r); end
      default: ;
    endcase
  end

  always_comb begin
    aop = '{sub: 1'b1, a: '0, b: '0};
    case (state_r)
      mjt_pkg::ST_DV:   aop = '{1'b1, ve, v0};
      mjt_pkg::ST_H1B:  aop = '{1'b1, x_r, at2_r};
      mjt_pkg::ST_DA:   aop = '{1'b1, ae, a0};
      mjt_pkg::ST_H0A:  aop = '{1'b1, pe, p0};
      mjt_pkg::ST_H0B:  aop = '{1'b1, h0_r, coef_r[1]};
      mjt_pkg::ST_H0C:  aop = '{1'b1, h0_r, coef_r[2]};
      mjt_pkg::ST_C3C, mjt_pkg::ST_C4C, mjt_pkg::ST_C5C: aop = '{1'b1, x_r, y_r};
      mjt_pkg::ST_C3D:  aop = '{1'b0, coef_r[3], h2h_r};
      mjt_pkg::ST_C4D:  aop = '{1'b1, x_r, h2_r};
      mjt_pkg::ST_C5D:  aop = '{1'b0, x_r, h2h_r};
      mjt_pkg::ST_HADD: aop = '{1'b0, acc_r, coef_r[k_r]};
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mjt_pkg::ST_IDLE: if (in_acc) state_nxt = mjt_pkg::ST_T2;
      mjt_pkg::ST_HMUL: if (mul_done) state_nxt = mjt_pkg::ST_HADD;
      mjt_pkg::ST_HADD: state_nxt = (k_r == 3'd0) ? mjt_pkg::ST_EMIT : mjt_pkg::ST_HMUL;
      mjt_pkg::ST_EMIT: begin
        if (out_acc) begin
          state_nxt = (idx_r == mjt_pkg::IDX_W'(mjt_pkg::SAMPLES - 1)) ?
                      mjt_pkg::ST_IDLE : mjt_pkg::ST_HMUL;
        end
      end
      mjt_pkg::ST_C5D: state_nxt = mjt_pkg::ST_HMUL;
      default: begin
        if (!is_mul(state_r) || mul_done) state_nxt = mjt_pkg::state_t'(state_r + 5'd1);
      end
    endcase
  end

  // Next sample time: add 2^F/SAMPLES and carry the remainder of 2^F mod SAMPLES
  always_comb begin
    rem_sum = rem_r + (mjt_pkg::IDX_W + 1)'(mjt_pkg::U_REM);
    if (rem_sum >= (mjt_pkg::IDX_W + 1)'(mjt_pkg::SAMPLES)) begin
      rem_nxt = rem_sum - (mjt_pkg::IDX_W + 1)'(mjt_pkg::SAMPLES);
      u_nxt   = u_r + (mjt_pkg::FRAC_BITS + 1)'(mjt_pkg::U_STEP + 1);
    end else begin
      rem_nxt = rem_sum;
      u_nxt   = u_r + (mjt_pkg::FRAC_BITS + 1)'(mjt_pkg::U_STEP);
    end
  end

  // Sequencer registers and datapath captures
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mjt_pkg::ST_IDLE;
      dur_r    <= mjt_pkg::DUR_RESET;
      mstart_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      mstart_r <= state_nxt != state_r || (state_r == mjt_pkg::ST_IDLE);
      if (cfg_valid && cfg_ready) dur_r <= cfg_duration;
    end
    if (in_acc) begin
      item_r <= in_data;
      coef_r[0] <= 64'(in_data.start_pos);
    end
    case (state_r)
      mjt_pkg::ST_T2:   if (mul_done) t2_r <= my;
      mjt_pkg::ST_AT2:  if (mul_done) at2_r <= my;
      mjt_pkg::ST_B1:   if (mul_done) coef_r[1] <= my;
      mjt_pkg::ST_B2:   if (mul_done) coef_r[2] <= my;
      mjt_pkg::ST_DV, mjt_pkg::ST_DA: x_r <= ay;
      mjt_pkg::ST_H1A:  if (mul_done) x_r <= my;
      mjt_pkg::ST_H1B:  h1_r <= ay;
      mjt_pkg::ST_H2:   if (mul_done) h2_r <= my;
      mjt_pkg::ST_H2H:  if (mul_done) h2h_r <= my;
      mjt_pkg::ST_H0A, mjt_pkg::ST_H0B, mjt_pkg::ST_H0C: h0_r <= ay;
      mjt_pkg::ST_C3A, mjt_pkg::ST_C4A, mjt_pkg::ST_C5A: if (mul_done) x_r <= my;
      mjt_pkg::ST_C3B, mjt_pkg::ST_C4B, mjt_pkg::ST_C5B: if (mul_done) y_r <= my;
      mjt_pkg::ST_C3C:  coef_r[3] <= ay;
      mjt_pkg::ST_C3D:  coef_r[3] <= ay;
      mjt_pkg::ST_C4C, mjt_pkg::ST_C5C: x_r <= ay;
      mjt_pkg::ST_C4D:  coef_r[4] <= ay;
      mjt_pkg::ST_C5D:  begin
        coef_r[5] <= ay; acc_r <= ay; k_r <= 3'd4;
        idx_r <= '0; u_r <= '0; rem_r <= '0;
      end
      mjt_pkg::ST_HMUL: if (mul_done) acc_r <= my;
      mjt_pkg::ST_HADD: begin acc_r <= ay; k_r <= k_r - 3'd1; end
      mjt_pkg::ST_EMIT: if (out_acc) begin
        idx_r <= idx_r + mjt_pkg::IDX_W'(1); acc_r <= coef_r[5]; k_r <= 3'd4;
        u_r <= u_nxt; rem_r <= rem_nxt;
      end
      default: ;
    endcase
  end

  // Output contents from the index and accumulator registers, position saturated to 32 bits
  always_comb begin
    out_data.sample_index = idx_r;
    out_data.last_sample  = idx_r == mjt_pkg::IDX_W'(mjt_pkg::SAMPLES - 1);
    if (acc_r > 64'sd2147483647)       out_data.sample_pos = 32'sh7fffffff;
    else if (acc_r < -64'sd2147483648) out_data.sample_pos = 32'sh80000000;
    else                               out_data.sample_pos = acc_r[31:0];
  end
endmodule
`default_nettype wire

>>> design/mjt_mulq.sv
// Shared fixed-point multiplier: floor(a*b/2^FRAC_BITS) saturated, result after four partial products
`default_nettype none
module mjt_mulq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      y
);
  // Magnitudes cut into 32-bit halves; one partial product per cycle
  logic [63:0]  ma_r, mb_r, ma_nxt, mb_nxt;
  logic         neg_r, neg_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] q;
  logic         frac_nz;
  logic [127:0] qn;

  always_comb begin
    pa = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    pb = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    pp_sh = {64'd0, pp} << (({6'd0, cnt_r[1]} + {6'd0, cnt_r[0]}) * 7'd32);
  end

  always_comb begin
    ma_nxt = ma_r; mb_nxt = mb_r; neg_nxt = neg_r;
    acc_nxt = acc_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      ma_nxt  = a[63] ? 64'(-a) : 64'(a);
      mb_nxt  = b[63] ? 64'(-b) : 64'(b);
      neg_nxt = a[63] ^ b[63];
      acc_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp_sh;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd3) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    ma_r <= ma_nxt; mb_r <= mb_nxt; neg_r <= neg_nxt; acc_r <= acc_nxt;
  end

  // Result valid the cycle after the 4th partial product, never in a start cycle
  assign done = !busy_r && !start && cnt_r == 3'd4;

  always_comb begin
    q = acc_r >> mjt_pkg::FRAC_BITS;
    frac_nz = |acc_r[mjt_pkg::FRAC_BITS-1:0];
    qn = q + {127'd0, frac_nz};
    if (!neg_r) begin
      y = (q[127:63] != '0) ? mjt_pkg::S64_MAX : $signed(q[63:0]);
    end else begin
      y = (qn[127:63] != '0) ? mjt_pkg::S64_MIN : $signed(64'(-qn[63:0]));
    end
  end
endmodule
`default_nettype wire

>>> design/mjt_sadd.sv
// Saturating 64-bit add/subtract
`default_nettype none
module mjt_sadd (
  input  wire mjt_pkg::alu_op_t   op,
  output logic signed [63:0]      y
);
  logic signed [64:0] s;
  always_comb begin
    s = op.sub ? (65'(op.a) - 65'(op.b)) : (65'(op.a) + 65'(op.b));
    if (s[64] != s[63]) y = s[64] ? mjt_pkg::S64_MIN : mjt_pkg::S64_MAX;
    else                y = s[63:0];
  end
endmodule
`default_nettype wire

>>> design/mjt_checker.sv
// Port-level checker for the trajectory sampler, bound to the top level
`default_nettype none
module mjt_port_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire mjt_pkg::out_item_t out_data,
  input wire logic cfg_ready
);
  // No results while idle and ready for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("result while idle");
  // Accepted item makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("not busy after accept");
  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result changed");
  // Last flag tracks final index
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_sample ==
      (out_data.sample_index == mjt_pkg::IDX_W'(mjt_pkg::SAMPLES - 1)))
    else $error("last flag wrong");
  // Config only taken while idle
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall) else $error("config while busy");
endmodule

bind min_jerk_trajectory_sampler_core mjt_port_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data, .cfg_ready
);
`default_nettype wire
